/* hw/rtl/utf8_sanitize_escaper_macros.svh */
// Assertion shorthands shared by the sanitizer modules.
// Every module that uses them has the clock aclk and the active-low reset aresetn.
`ifndef UTF8_SANITIZE_ESCAPER_MACROS_SVH
`define UTF8_SANITIZE_ESCAPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8SE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8SE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/utf8se_pkg.sv */
`timescale 1ns / 1ps

package utf8se_pkg;

    // Kinds of output token. Each token expands into one to six output bytes.
    typedef enum logic [1:0] {
        TOK_RAW = 2'd0,   // the byte itself
        TOK_ESC = 2'd1,   // backslash and a letter
        TOK_HEX = 2'd2,   // \xNN of the byte
        TOK_UNI = 2'd3    // \u00NN of a C1 control
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] data;
    } tok_t;

    // One token together with the end marks of the request that caused it.
    typedef struct packed {
        tok_t tok;
        logic run_last;
        logic text_last;
    } cmd_t;

    localparam int PlanDepth  = 5;
    localparam int PlanCntW   = 3;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;
    localparam int QueueCntW  = 3;

    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChX         = 8'h78;
    localparam logic [7:0] ChU         = 8'h75;
    localparam logic [7:0] ChN         = 8'h6E;
    localparam logic [7:0] ChR         = 8'h72;
    localparam logic [7:0] ChT         = 8'h74;
    localparam logic [7:0] ChZero      = 8'h30;

    // Number of output bytes a token expands into.
    function automatic logic [2:0] tok_len(input tok_kind_t kind);
        logic [2:0] len;
        case (kind)
            TOK_RAW: len = 3'd1;
            TOK_ESC: len = 3'd2;
            TOK_HEX: len = 3'd4;
            TOK_UNI: len = 3'd6;
            default: len = 3'd1;
        endcase
        return len;
    endfunction

    // Upper-case ASCII hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] ch;
        if (v < 4'd10) begin
            ch = ChZero + {4'd0, v};
        end else begin
            ch = 8'h37 + {4'd0, v};
        end
        return ch;
    endfunction

endpackage

/* hw/rtl/utf8se_front.sv */
`timescale 1ns / 1ps
`include "utf8_sanitize_escaper_macros.svh"

module utf8se_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    output logic              q_push,
    output utf8se_pkg::cmd_t  q_data,
    input  logic              q_full
);

    // Decoder state.
    logic [7:0]  held_reg [3];
    logic [7:0]  held_next [3];
    logic [1:0]  held_cnt_reg, held_cnt_next;
    logic [2:0]  exp_len_reg, exp_len_next;
    logic [20:0] pv_reg, pv_next;

    // Token plan of the request being issued to the queue.
    utf8se_pkg::tok_t plan_reg [utf8se_pkg::PlanDepth];
    utf8se_pkg::tok_t plan_next [utf8se_pkg::PlanDepth];
    utf8se_pkg::tok_t plan_new [utf8se_pkg::PlanDepth];
    logic [utf8se_pkg::PlanCntW-1:0] plan_cnt_reg, plan_cnt_next, plan_cnt_new;
    logic plan_end_reg, plan_end_next;

    logic [7:0] b;
    logic       accept;

    // Decode of the byte as a fresh lead.
    utf8se_pkg::tok_t start_tok;
    logic             start_v;
    logic             start_lead;
    logic [2:0]       start_len;
    logic [20:0]      start_pv;

    logic             pend, is_cont, complete, bad, ctrl_cp, flush_end;
    logic [20:0]      pv_cat;
    logic [1:0]       pre_n, post_n;
    utf8se_pkg::tok_kind_t pre_kind;
    logic             mid_v;
    utf8se_pkg::tok_t mid_tok;

    assign b = s_tdata;

    always_comb begin
        start_tok  = '{kind: utf8se_pkg::TOK_RAW, data: b};
        start_v    = 1'b1;
        start_lead = 1'b0;
        start_len  = 3'd0;
        start_pv   = 21'd0;
        if (!b[7]) begin
            if (b == 8'h0A) begin
                start_tok = '{kind: utf8se_pkg::TOK_ESC, data: utf8se_pkg::ChN};
            end else if (b == 8'h0D) begin
                start_tok = '{kind: utf8se_pkg::TOK_ESC, data: utf8se_pkg::ChR};
            end else if (b == 8'h09) begin
                start_tok = '{kind: utf8se_pkg::TOK_ESC, data: utf8se_pkg::ChT};
            end else if (b < 8'h20 || b == 8'h7F) begin
                start_tok = '{kind: utf8se_pkg::TOK_HEX, data: b};
            end
        end else if (b[7:5] == 3'b110) begin
            start_v    = 1'b0;
            start_lead = 1'b1;
            start_len  = 3'd2;
            start_pv   = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            start_v    = 1'b0;
            start_lead = 1'b1;
            start_len  = 3'd3;
            start_pv   = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            start_v    = 1'b0;
            start_lead = 1'b1;
            start_len  = 3'd4;
            start_pv   = {18'd0, b[2:0]};
        end else begin
            start_tok = '{kind: utf8se_pkg::TOK_HEX, data: b};
        end
    end

    assign pend     = (exp_len_reg != 3'd0);
    assign is_cont  = (b[7:6] == 2'b10);
    assign pv_cat   = {pv_reg[14:0], b[5:0]};
    assign complete = (({1'b0, held_cnt_reg} + 3'd1) >= exp_len_reg);
    assign bad      = (exp_len_reg == 3'd2 && pv_cat < 21'h80)
                   || (exp_len_reg == 3'd3 && pv_cat < 21'h800)
                   || (exp_len_reg == 3'd4 && pv_cat < 21'h10000)
                   || (pv_cat > 21'h10FFFF)
                   || (pv_cat >= 21'hD800 && pv_cat <= 21'hDFFF);
    assign ctrl_cp  = (pv_cat < 21'h20) || (pv_cat == 21'h7F)
                   || (pv_cat >= 21'h80 && pv_cat <= 21'h9F);

    // Next decoder state and the three parts of the token plan: flushed or
    // passed held bytes, one token for the current byte, end-of-text flush.
    always_comb begin
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        exp_len_next  = exp_len_reg;
        pv_next       = pv_reg;
        pre_n         = 2'd0;
        pre_kind      = utf8se_pkg::TOK_HEX;
        mid_v         = 1'b0;
        mid_tok       = start_tok;
        if (!pend || !is_cont) begin
            if (pend) begin
                pre_n = held_cnt_reg;
            end
            mid_v = start_v;
            if (start_lead) begin
                held_next[0]  = b;
                held_cnt_next = 2'd1;
                exp_len_next  = start_len;
                pv_next       = start_pv;
            end else begin
                held_cnt_next = 2'd0;
                exp_len_next  = 3'd0;
                pv_next       = 21'd0;
            end
        end else if (!complete) begin
            case (held_cnt_reg)
                2'd0:    held_next[0] = b;
                2'd1:    held_next[1] = b;
                default: held_next[2] = b;
            endcase
            held_cnt_next = held_cnt_reg + 2'd1;
            pv_next       = pv_cat;
        end else begin
            held_cnt_next = 2'd0;
            exp_len_next  = 3'd0;
            pv_next       = 21'd0;
            pre_n         = held_cnt_reg;
            mid_v         = 1'b1;
            if (bad) begin
                mid_tok = '{kind: utf8se_pkg::TOK_HEX, data: b};
            end else if (ctrl_cp) begin
                pre_n   = 2'd0;
                mid_tok = '{kind: utf8se_pkg::TOK_UNI, data: pv_cat[7:0]};
            end else begin
                pre_kind = utf8se_pkg::TOK_RAW;
                mid_tok  = '{kind: utf8se_pkg::TOK_RAW, data: b};
            end
        end
        flush_end = s_tlast && (exp_len_next != 3'd0);
        post_n    = flush_end ? held_cnt_next : 2'd0;
        if (flush_end) begin
            held_cnt_next = 2'd0;
            exp_len_next  = 3'd0;
            pv_next       = 21'd0;
        end
    end

    // Pack the plan parts into consecutive slots.
    always_comb begin
        plan_cnt_new = '0;
        for (int i = 0; i < utf8se_pkg::PlanDepth; i++) begin
            plan_new[i] = '{kind: utf8se_pkg::TOK_RAW, data: 8'd0};
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < pre_n) begin
                plan_new[plan_cnt_new] = '{kind: pre_kind, data: held_reg[i]};
                plan_cnt_new = plan_cnt_new + 3'd1;
            end
        end
        if (mid_v) begin
            plan_new[plan_cnt_new] = mid_tok;
            plan_cnt_new = plan_cnt_new + 3'd1;
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < post_n) begin
                plan_new[plan_cnt_new] = '{kind: utf8se_pkg::TOK_HEX, data: held_next[i]};
                plan_cnt_new = plan_cnt_new + 3'd1;
            end
        end
    end

    assign q_push   = (plan_cnt_reg != '0) && !q_full;
    assign s_tready = (plan_cnt_reg == '0) || (plan_cnt_reg == 3'd1 && q_push);
    assign accept   = s_tvalid && s_tready;

    assign q_data = '{tok: plan_reg[0],
                      run_last: (plan_cnt_reg == 3'd1),
                      text_last: (plan_cnt_reg == 3'd1) && plan_end_reg};

    always_comb begin
        plan_next     = plan_reg;
        plan_cnt_next = plan_cnt_reg;
        plan_end_next = plan_end_reg;
        if (q_push) begin
            for (int i = 0; i < utf8se_pkg::PlanDepth - 1; i++) begin
                plan_next[i] = plan_reg[i + 1];
            end
            plan_cnt_next = plan_cnt_reg - 3'd1;
        end
        if (accept) begin
            plan_next     = plan_new;
            plan_cnt_next = plan_cnt_new;
            plan_end_next = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt_reg <= 2'd0;
            exp_len_reg  <= 3'd0;
            pv_reg       <= 21'd0;
            plan_cnt_reg <= '0;
        end else begin
            plan_cnt_reg <= plan_cnt_next;
            if (accept) begin
                held_cnt_reg <= held_cnt_next;
                exp_len_reg  <= exp_len_next;
                pv_reg       <= pv_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        plan_reg     <= plan_next;
        plan_end_reg <= plan_end_next;
        if (accept) begin
            held_reg <= held_next;
        end
    end

    `U8SE_ASSERT_NOW(a_idle_no_held, exp_len_reg == 3'd0, held_cnt_reg == 2'd0,
        "bytes held with no sequence pending")
    `U8SE_ASSERT_NOW(a_held_below_len, exp_len_reg != 3'd0,
        ({1'b0, held_cnt_reg} < exp_len_reg) && (held_cnt_reg != 2'd0),
        "held byte count out of step with sequence length")
    `U8SE_ASSERT_NOW(a_accept_plan_drained, accept, plan_cnt_reg <= 3'd1,
        "request accepted over an unfinished token plan")

endmodule

/* hw/rtl/utf8se_queue.sv */
`timescale 1ns / 1ps
`include "utf8_sanitize_escaper_macros.svh"

module utf8se_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  utf8se_pkg::cmd_t push_data,
    output logic             full,
    input  logic             pop,
    output utf8se_pkg::cmd_t head,
    output logic             empty
);

    utf8se_pkg::cmd_t mem_reg [utf8se_pkg::QueueDepth];
    logic [utf8se_pkg::QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [utf8se_pkg::QueueCntW-1:0] cnt_reg;

    assign full  = (cnt_reg == utf8se_pkg::QueueCntW'(utf8se_pkg::QueueDepth));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `U8SE_ASSERT_NOW(a_no_overflow, push, !full || pop, "token queue overflow")
    `U8SE_ASSERT_NOW(a_no_underflow, pop, !empty, "token queue underflow")
    `U8SE_ASSERT_NEXT(a_count_up, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1,
        "token queue count did not follow a push")

endmodule

/* hw/rtl/utf8se_back.sv */
`timescale 1ns / 1ps
`include "utf8_sanitize_escaper_macros.svh"

module utf8se_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  utf8se_pkg::cmd_t q_head,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    logic [2:0] step_reg;
    logic [2:0] len;
    logic       load, tok_done;
    logic [7:0] ch;
    logic       m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [7:0] m_tdata_reg;

    assign len      = utf8se_pkg::tok_len(q_head.tok.kind);
    assign tok_done = (step_reg == len - 3'd1);
    assign load     = !q_empty && (!m_tvalid_reg || m_tready);
    assign q_pop    = load && tok_done;

    // Byte of the current token at the current step.
    always_comb begin
        ch = q_head.tok.data;
        case (q_head.tok.kind)
            utf8se_pkg::TOK_RAW: ch = q_head.tok.data;
            utf8se_pkg::TOK_ESC: begin
                ch = (step_reg == 3'd0) ? utf8se_pkg::ChBackslash : q_head.tok.data;
            end
            utf8se_pkg::TOK_HEX: begin
                case (step_reg)
                    3'd0:    ch = utf8se_pkg::ChBackslash;
                    3'd1:    ch = utf8se_pkg::ChX;
                    3'd2:    ch = utf8se_pkg::hex_digit(q_head.tok.data[7:4]);
                    default: ch = utf8se_pkg::hex_digit(q_head.tok.data[3:0]);
                endcase
            end
            utf8se_pkg::TOK_UNI: begin
                case (step_reg)
                    3'd0:    ch = utf8se_pkg::ChBackslash;
                    3'd1:    ch = utf8se_pkg::ChU;
                    3'd2:    ch = utf8se_pkg::ChZero;
                    3'd3:    ch = utf8se_pkg::ChZero;
                    3'd4:    ch = utf8se_pkg::hex_digit(q_head.tok.data[7:4]);
                    default: ch = utf8se_pkg::hex_digit(q_head.tok.data[3:0]);
                endcase
            end
            default: ch = q_head.tok.data;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                step_reg     <= tok_done ? 3'd0 : step_reg + 3'd1;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= ch;
            m_tuser_reg <= tok_done && q_head.run_last;
            m_tlast_reg <= tok_done && q_head.text_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `U8SE_ASSERT_NOW(a_step_in_token, !q_empty, step_reg < len,
        "expansion step beyond token length")
    `U8SE_ASSERT_NOW(a_step_idle, q_empty, step_reg == 3'd0,
        "expansion step left over with no token queued")
    `U8SE_ASSERT_NOW(a_text_last_ends_run, m_tvalid && m_tlast, m_tuser,
        "end of text on a byte that does not end its request")

endmodule

/* hw/rtl/utf8_sanitize_escaper.sv */
`timescale 1ns / 1ps
// UTF-8 sanitizer with control escaping. Input requests arrive on the s_ stream one
// text byte each, with s_tlast marking the final byte of a text. Output requests leave
// on the m_ stream one byte each: valid printable sequences pass unchanged, controls
// become \n, \r, \t, \xNN or \u00NN, and malformed bytes become \xNN, all in upper case.
// m_tuser marks the last output byte caused by one input byte, m_tlast the last
// output byte of the whole text. An input byte may cause no output at all.
// The front decodes a byte in the cycle it is accepted and turns it into a plan of
// up to four tokens, issuing one token a cycle into a four-entry queue while it has
// room. It accepts a new byte every cycle as long as each byte yields at most one token
// and the queue has room; a byte that yields more tokens holds the input until its
// last token is issued. The back expands one output byte a cycle from the queue
// head while the receiver is ready (1, 2, 4 or 6 bytes per token), so one input byte
// yields 0 to 16 output bytes, and the output byte rate sets sustained throughput.
// When the receiver stalls, the output register holds, the queue fills, and then
// the front stops taking bytes. Reset clears the pending sequence, the queue and the
// output valid; no clearing pass is needed.

module utf8_sanitize_escaper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // text_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] run_last
    output logic       m_tlast    // text_last
);

    // Tokens travel from the decoder to the expander through a short queue.
    logic             q_push, q_full, q_pop, q_empty;
    utf8se_pkg::cmd_t q_in, q_head;

    utf8se_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_data   (q_in),
        .q_full   (q_full)
    );

    utf8se_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // The expander owns the output register, which also decouples the receiver.
    utf8se_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* tb/sv/utf8_sanitize_escaper_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the UTF-8 sanitizer.
//
// A short table of directed input bytes runs first. Some rows carry the output text typed
// in by hand. Those rows start with no sequence pending, so the escape can be read off
// directly. Every other row, and all random traffic after the table, is checked against
// a predictor that decodes the byte stream the same way the block should.
//
// The random traffic is mostly well-formed sequences of one to four bytes. It is mixed
// with controls, C1 controls, truncated or broken sequences and raw noise bytes.
// It runs under three stall patterns. First the sender is slow and the receiver very
// slow, then the reverse, then both sides run at full rate.
module utf8_sanitize_escaper_test;

    localparam int CycleLimit = 300000;
    localparam int RandItems  = 81;

    localparam logic [7:0] ChBsl = 8'h5C;
    localparam logic [7:0] ChX   = 8'h78;
    localparam logic [7:0] ChU   = 8'h75;
    localparam logic [7:0] ChN   = 8'h6E;
    localparam logic [7:0] ChR   = 8'h72;
    localparam logic [7:0] ChT   = 8'h74;

    // One expected output request: the byte and its two end marks.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_last;
    } out_rec_t;

    // One directed row. An empty want string means the predictor decides the output.
    typedef struct {
        logic [7:0] b;
        logic       fin;
        string      want;
    } stim_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    utf8_sanitize_escaper uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [7:0] in_byte
        .s_tlast (s_tlast),   // text_end
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // [7:0] out_byte
        .m_tuser (m_tuser),   // [0] run_last
        .m_tlast (m_tlast)    // text_last
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Percentages of cycles in which each side holds back.
    int src_idle = 26;
    int sink_idle = 87;

    // Hand-typed output text for the request being offered, empty when predicted.
    string want_text = "";

    out_rec_t  expected_out[$];
    stim_row_t dir_rows[27];

    int fail_count = 0;
    int items_seen = 0;
    int texts_seen = 0;
    int results_seen = 0;
    int rand_items = 0;
    int cycle_count = 0;

    // Predictor state: the buffered lead and continuations, their count, the length
    // the lead promised (zero when nothing is pending) and the code point bits so far.
    logic [7:0]  seq_held[3];
    logic [1:0]  seq_held_n = 2'd0;
    logic [2:0]  seq_len = 3'd0;
    logic [20:0] seq_cp = 21'd0;

    // Output bytes that the current input byte produces.
    logic [7:0]  step_bytes[$];

    function automatic logic [7:0] nibble_ch(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'd0, v};
        end
        return 8'h41 + {4'd0, v} - 8'd10;
    endfunction

    function automatic logic is_ctrl_cp(input logic [20:0] cp);
        return cp < 21'h20 || cp == 21'h7F || (cp >= 21'h80 && cp <= 21'h9F);
    endfunction

    task automatic emit_hex(input logic [7:0] b);
        step_bytes.push_back(ChBsl);
        step_bytes.push_back(ChX);
        step_bytes.push_back(nibble_ch(b[7:4]));
        step_bytes.push_back(nibble_ch(b[3:0]));
    endtask

    // Give up on the pending sequence: every buffered byte goes out as \xNN.
    task automatic drop_seq();
        for (int i = 0; i < seq_held_n; i++) begin
            emit_hex(seq_held[i]);
        end
        seq_held_n = 2'd0;
        seq_len = 3'd0;
        seq_cp = 21'd0;
    endtask

    task automatic emit_ctrl(input logic [20:0] cp);
        if (cp == 21'h0A) begin
            step_bytes.push_back(ChBsl);
            step_bytes.push_back(ChN);
        end else if (cp == 21'h0D) begin
            step_bytes.push_back(ChBsl);
            step_bytes.push_back(ChR);
        end else if (cp == 21'h09) begin
            step_bytes.push_back(ChBsl);
            step_bytes.push_back(ChT);
        end else if (cp <= 21'h7F) begin
            emit_hex(cp[7:0]);
        end else begin
            step_bytes.push_back(ChBsl);
            step_bytes.push_back(ChU);
            step_bytes.push_back(nibble_ch(cp[15:12]));
            step_bytes.push_back(nibble_ch(cp[11:8]));
            step_bytes.push_back(nibble_ch(cp[7:4]));
            step_bytes.push_back(nibble_ch(cp[3:0]));
        end
    endtask

    // Decode a byte with nothing pending: ASCII goes out at once, a lead opens a
    // sequence, and anything else is an invalid lead.
    task automatic open_seq(input logic [7:0] b);
        if (b < 8'h80) begin
            if (is_ctrl_cp({13'd0, b})) begin
                emit_ctrl({13'd0, b});
            end else begin
                step_bytes.push_back(b);
            end
        end else if (b[7:5] == 3'b110) begin
            seq_len = 3'd2;
            seq_cp = {16'd0, b[4:0]};
            seq_held[0] = b;
            seq_held_n = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            seq_len = 3'd3;
            seq_cp = {17'd0, b[3:0]};
            seq_held[0] = b;
            seq_held_n = 2'd1;
        end else if (b[7:3] == 5'b11110) begin
            seq_len = 3'd4;
            seq_cp = {18'd0, b[2:0]};
            seq_held[0] = b;
            seq_held_n = 2'd1;
        end else begin
            emit_hex(b);
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic fin);
        logic [20:0] cp;
        logic        bad;
        step_bytes.delete();
        if (seq_len == 3'd0) begin
            open_seq(b);
        end else if (b[7:6] != 2'b10) begin
            // The sequence is broken; the breaking byte starts over as a lead.
            drop_seq();
            open_seq(b);
        end else begin
            cp = {seq_cp[14:0], b[5:0]};
            seq_cp = cp;
            if ({1'b0, seq_held_n} + 3'd1 < seq_len) begin
                seq_held[seq_held_n] = b;
                seq_held_n = seq_held_n + 2'd1;
            end else begin
                bad = (seq_len == 3'd2 && cp < 21'h80) ||
                      (seq_len == 3'd3 && cp < 21'h800) ||
                      (seq_len == 3'd4 && cp < 21'h10000) ||
                      cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF);
                if (bad) begin
                    drop_seq();
                    emit_hex(b);
                end else begin
                    if (is_ctrl_cp(cp)) begin
                        emit_ctrl(cp);
                    end else begin
                        for (int i = 0; i < seq_held_n; i++) begin
                            step_bytes.push_back(seq_held[i]);
                        end
                        step_bytes.push_back(b);
                    end
                    seq_held_n = 2'd0;
                    seq_len = 3'd0;
                    seq_cp = 21'd0;
                end
            end
        end
        // A text that ends inside a sequence flushes it as \xNN.
        if (fin && seq_len != 3'd0) begin
            drop_seq();
        end
    endtask

    task automatic log_mismatch(input string what, input out_rec_t want, input out_rec_t got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: %s: expected %02h run %0b text %0b, got %02h run %0b text %0b",
                     $time, what, want.data, want.run_last, want.text_last,
                     got.data, got.run_last, got.text_last);
        end
    endtask

    // Both channels are sampled at the rising edge. The predictor runs on each accepted
    // input request and queues the results it expects; each accepted output request is
    // checked against the oldest of them.
    always @(posedge aclk) begin : scoreboard
        out_rec_t want;
        out_rec_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata, s_tlast);
                if (want_text.len() != 0) begin
                    step_bytes.delete();
                    for (int k = 0; k < want_text.len(); k++) begin
                        step_bytes.push_back(want_text[k]);
                    end
                end
                for (int k = 0; k < step_bytes.size(); k++) begin
                    want.data = step_bytes[k];
                    want.run_last = (k == step_bytes.size() - 1);
                    want.text_last = want.run_last && s_tlast;
                    expected_out.push_back(want);
                end
                items_seen++;
                if (s_tlast) begin
                    texts_seen++;
                end
            end
            if (m_tvalid && m_tready) begin
                got.data = m_tdata;
                got.run_last = m_tuser;
                got.text_last = m_tlast;
                if (expected_out.size() == 0) begin
                    log_mismatch("output with nothing expected", '0, got);
                end else begin
                    want = expected_out.pop_front();
                    if (got != want) begin
                        log_mismatch("output mismatch", want, got);
                    end
                    results_seen++;
                end
            end
        end
    end

    // The receiver decides at each falling edge whether to take the next output request.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= sink_idle);
    end

    // Offer one input byte, after a random number of idle cycles, and return at the
    // falling edge after it was accepted. Valid stays high on return so that back-to-back
    // requests keep it high without a gap.
    task automatic offer_byte(input logic [7:0] b, input logic fin, input string want);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tlast = fin;
        want_text = want;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic send_rand(input logic [7:0] b, input logic fin);
        offer_byte(b, fin, "");
        rand_items++;
    endtask

    function automatic logic pick_end();
        return $urandom_range(0, 9) == 0;
    endfunction

    function automatic logic [7:0] pick_lead(input int len);
        logic [7:0] lead;
        case (len)
            1: lead = 8'($urandom_range(8'h00, 8'h7F));
            2: lead = 8'($urandom_range(8'hC0, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF7));
        endcase
        return lead;
    endfunction

    function automatic logic [7:0] pick_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // One random group of input bytes. Most groups are whole sequences with random
    // content, so decoding reaches the range and overlong checks; the rest are controls,
    // sequences cut short by a stray byte or by the end of the text, and noise.
    task automatic random_group();
        int         kind;
        int         len;
        int         n;
        logic       ending;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            len = $urandom_range(1, 4);
            send_rand(pick_lead(len), (len == 1) && pick_end());
            for (int i = 1; i < len; i++) begin
                send_rand(pick_cont(), (i == len - 1) && pick_end());
            end
        end else if (kind < 70) begin
            if ($urandom_range(0, 1) == 0) begin
                b = ($urandom_range(0, 7) == 0) ? 8'h7F : 8'($urandom_range(0, 31));
                send_rand(b, pick_end());
            end else begin
                // Two-byte encodings of the C1 controls.
                send_rand(8'hC2, 1'b0);
                send_rand(8'h80 | 8'($urandom_range(0, 31)), pick_end());
            end
        end else if (kind < 85) begin
            len = $urandom_range(2, 4);
            n = $urandom_range(0, len - 2);
            ending = ($urandom_range(0, 2) == 0);
            send_rand(pick_lead(len), ending && (n == 0));
            for (int i = 0; i < n; i++) begin
                send_rand(pick_cont(), ending && (i == n - 1));
            end
            if (!ending) begin
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10) begin
                    b[6] = 1'b1;
                end
                send_rand(b, pick_end());
            end
        end else begin
            send_rand(8'($urandom_range(0, 255)), pick_end());
        end
    endtask

    initial begin
        // Bytes of one row only escape when no sequence is pending before it.
        dir_rows = '{
            '{8'h41, 1'b0, "A"},
            '{8'h00, 1'b0, "\\x00"},
            '{8'h0A, 1'b0, "\\n"},
            '{8'h0D, 1'b0, "\\r"},
            '{8'h09, 1'b0, "\\t"},
            '{8'h7F, 1'b0, "\\x7F"},
            '{8'hFF, 1'b0, "\\xFF"},
            '{8'h80, 1'b0, "\\x80"},
            '{8'hC2, 1'b0, ""},      // C1 control at the top of its range
            '{8'h9F, 1'b0, ""},
            '{8'hE2, 1'b0, ""},      // plain three-byte sequence
            '{8'h82, 1'b0, ""},
            '{8'hAC, 1'b0, ""},
            '{8'hF4, 1'b0, ""},      // largest legal code point
            '{8'h8F, 1'b0, ""},
            '{8'hBF, 1'b0, ""},
            '{8'hBF, 1'b0, ""},
            '{8'hC1, 1'b0, ""},      // overlong two-byte form
            '{8'hBF, 1'b0, ""},
            '{8'hED, 1'b0, ""},      // surrogate
            '{8'hA0, 1'b0, ""},
            '{8'h80, 1'b0, ""},
            '{8'hF7, 1'b0, ""},      // four-byte lead broken by a new lead
            '{8'hBF, 1'b0, ""},
            '{8'hE2, 1'b0, ""},
            '{8'hC3, 1'b1, ""},      // breaks the E2, then flushed by the end of text
            '{8'h7E, 1'b0, "~"}
        };
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            offer_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle = 26;
                    sink_idle = 87;
                end
                1: begin
                    src_idle = 87;
                    sink_idle = 26;
                end
                default: begin
                    src_idle = 0;
                    sink_idle = 0;
                end
            endcase
            while (rand_items < (RandItems * (phase + 1)) / 3) begin
                random_group();
            end
        end
        // Close the last text so that any pending sequence is flushed.
        send_rand(8'h2E, 1'b1);
        s_tvalid = 1'b0;

        while (expected_out.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        $display("Sent %0d input bytes in %0d texts and checked %0d output bytes.",
                 items_seen, texts_seen, results_seen);
        $display("Valid, control, broken and noise bytes under three stall mixes; %0d failures.",
                 fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing output ends the run here.
    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d outputs still expected.",
                 cycle_count, expected_out.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/utf8se_pkg.sv
hw/rtl/utf8se_front.sv
hw/rtl/utf8se_queue.sv
hw/rtl/utf8se_back.sv
hw/rtl/utf8_sanitize_escaper.sv
tb/sv/utf8_sanitize_escaper_test.sv
